// ===== design/vgn_pkg.sv =====
package vgn_pkg;

   // Field and register widths
   localparam int SAMPLE_W = 17;
   localparam int BYTE_W   = 8;
   localparam int FMT_W    = 2;

   // Sample format codes (the unused code behaves as unsigned byte)
   localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
   localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
   localparam logic [FMT_W-1:0] FMT_U16 = 2'd2;

   // Gradient lanes: x, y, z
   localparam int LANES = 3;

   // Normalized square sum: S * 2^e lies in [2^ALIGN_MSB, 2^(ALIGN_MSB+2))
   localparam int ALIGN_MSB = 60;
   localparam int X_W       = 62;
   localparam int ROOT_W    = 31;
   localparam int REM_W     = 33;

   // Fraction bits of the unit normal components
   localparam int NORM_FRAC_BITS_DEF = 16;

   // Per-item sideband that rides along the root and divide stages
   typedef struct packed {
      logic              zero;
      logic [LANES-1:0]  neg;
      logic [BYTE_W-1:0] alpha;
   } side_type;

endpackage

// ===== design/volume_gradient_normal_encoder.sv =====
// Channel  Ports                         Flow control
// -------  ----------------------------  -------------------------------------
// req      start, busy, req_*_sample     beat taken when start && !busy
// rsp      rsp_valid, rsp_normal_*,      beat shown for one cycle, always taken
//          rsp_alpha_byte
// csr      csr_valid, csr_ready,         beat taken when csr_valid && csr_ready
//          csr_sample_format
//
// One voxel per cycle; every beat is independent of the ones around it.
// There are six front stages (decode, magnitude, square, sum, leading-one,
// shift), 31 root stages at one bit each, NORM_FRAC_BITS + 1 divide stages
// at one bit each, and the output register.
// Reset is synchronous; it clears all valid bits and sets the format to
// unsigned byte. busy stays low and the receiver cannot stall, so the
// pipeline never holds.
module volume_gradient_normal_encoder #(
   parameter int NORM_FRAC_BITS = vgn_pkg::NORM_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [vgn_pkg::SAMPLE_W-1:0]   req_left_sample,
   input  logic signed [vgn_pkg::SAMPLE_W-1:0]   req_right_sample,
   input  logic signed [vgn_pkg::SAMPLE_W-1:0]   req_below_sample,
   input  logic signed [vgn_pkg::SAMPLE_W-1:0]   req_above_sample,
   input  logic signed [vgn_pkg::SAMPLE_W-1:0]   req_out_sample,
   input  logic signed [vgn_pkg::SAMPLE_W-1:0]   req_in_sample,
   input  logic signed [vgn_pkg::SAMPLE_W-1:0]   req_center_sample,
   output logic                                  rsp_valid,
   output logic [vgn_pkg::BYTE_W-1:0]            rsp_normal_x,
   output logic [vgn_pkg::BYTE_W-1:0]            rsp_normal_y,
   output logic [vgn_pkg::BYTE_W-1:0]            rsp_normal_z,
   output logic [vgn_pkg::BYTE_W-1:0]            rsp_alpha_byte,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vgn_pkg::FMT_W-1:0]             csr_sample_format
);

   localparam int SAMPLE_W     = vgn_pkg::SAMPLE_W;
   localparam int BYTE_W       = vgn_pkg::BYTE_W;
   localparam int LANES        = vgn_pkg::LANES;
   localparam int ROOT_W       = vgn_pkg::ROOT_W;
   localparam int X_W          = vgn_pkg::X_W;
   localparam int DIFF_W       = 17;
   localparam int MAG_W        = 16;
   localparam int SQ_W         = 2 * MAG_W;
   localparam int SUM_W        = SQ_W + 2;
   localparam int MSB_W        = 6;
   localparam int HALF_E_W     = 5;
   localparam int S16_SHIFT    = 7;
   localparam int SCALE_SHIFT  = 7;
   localparam int FRONT_STAGES = 6;
   localparam int LATENCY      = FRONT_STAGES + ROOT_W + NORM_FRAC_BITS + 2;
   localparam int V_W          = NORM_FRAC_BITS + 2;
   localparam logic [SAMPLE_W-1:0]       S16_BIAS   = SAMPLE_W'((1 << S16_SHIFT) - 1);
   localparam logic [V_W-1:0]            V_ONE      = {2'b01, {NORM_FRAC_BITS{1'b0}}};
   localparam logic [NORM_FRAC_BITS:0]   Q_ONE      = {1'b1, {NORM_FRAC_BITS{1'b0}}};
   localparam logic [BYTE_W-1:0]         NORMAL_MID = 8'd128;
   localparam logic [BYTE_W-1:0]         BYTE_MAX   = 8'd255;

   // Read a raw sample under the current format
   function automatic logic [SAMPLE_W-1:0] decode_sample(
      input logic [SAMPLE_W-1:0]         raw,
      input logic [vgn_pkg::FMT_W-1:0]   fmt
   );
      logic [SAMPLE_W-1:0] val;
      case (fmt)
         vgn_pkg::FMT_S16: val = {{(SAMPLE_W-16){raw[15]}}, raw[15:0]};
         vgn_pkg::FMT_U16: val = {{(SAMPLE_W-16){1'b0}}, raw[15:0]};
         default:          val = {{(SAMPLE_W-8){1'b0}}, raw[7:0]};
      endcase
      return val;
   endfunction

   logic [vgn_pkg::FMT_W-1:0]     fmt_ff;
   logic                          accept;

   logic [LANES-1:0][SAMPLE_W-1:0] dec_a;
   logic [LANES-1:0][SAMPLE_W-1:0] dec_b;
   logic [SAMPLE_W-1:0]            center_dec;
   logic [SAMPLE_W-1:0]            center_adj;
   logic [LANES-1:0][DIFF_W-1:0]   diff_in;
   logic [BYTE_W-1:0]              alpha_in;

   logic                          s1_valid_ff;
   logic [LANES-1:0][DIFF_W-1:0]  s1_diff_ff;
   logic [BYTE_W-1:0]             s1_alpha_ff;

   logic                          s2_valid_ff;
   logic [LANES-1:0][MAG_W-1:0]   s2_mag_ff;
   logic [LANES-1:0]              s2_neg_ff;
   logic [BYTE_W-1:0]             s2_alpha_ff;
   logic [LANES-1:0][MAG_W-1:0]   mag_in;
   logic [LANES-1:0][DIFF_W-1:0]  abs_val;

   logic                          s3_valid_ff;
   logic [LANES-1:0][SQ_W-1:0]    s3_sq_ff;
   logic [LANES-1:0][MAG_W-1:0]   s3_mag_ff;
   logic [LANES-1:0]              s3_neg_ff;
   logic [BYTE_W-1:0]             s3_alpha_ff;

   logic                          s4_valid_ff;
   logic [SUM_W-1:0]              s4_sum_ff;
   logic [LANES-1:0][MAG_W-1:0]   s4_mag_ff;
   logic [LANES-1:0]              s4_neg_ff;
   logic [BYTE_W-1:0]             s4_alpha_ff;

   logic [MSB_W-1:0]              msb;
   logic [MSB_W:0]                span;
   logic                          s5_valid_ff;
   logic [SUM_W-1:0]              s5_sum_ff;
   logic [HALF_E_W-1:0]           s5_half_e_ff;
   logic                          s5_zero_ff;
   logic [LANES-1:0][MAG_W-1:0]   s5_mag_ff;
   logic [LANES-1:0]              s5_neg_ff;
   logic [BYTE_W-1:0]             s5_alpha_ff;

   logic                          s6_valid_ff;
   logic [X_W-1:0]                s6_x_ff;
   logic [LANES-1:0][ROOT_W-1:0]  s6_m_ff;
   vgn_pkg::side_type             s6_side_ff;
   logic [LANES-1:0][ROOT_W-1:0]  m_in;

   logic                                pipe_valid;
   logic [LANES-1:0][NORM_FRAC_BITS:0]  pipe_q;
   vgn_pkg::side_type                   pipe_side;

   logic [LANES-1:0][V_W-1:0]     biased;
   logic [LANES-1:0][BYTE_W-1:0]  normal_in;
   logic                          rsp_valid_ff;
   logic [LANES-1:0][BYTE_W-1:0]  rsp_normal_ff;
   logic [BYTE_W-1:0]             rsp_alpha_ff;

   // Input and config handshakes: the pipeline never holds
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Hold the sample format
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= vgn_pkg::FMT_U8;
      end else if (csr_valid && csr_ready) begin
         fmt_ff <= csr_sample_format;
      end
   end

   // Stage 1: decode samples, take central differences, scale the alpha byte
   always_comb begin
      dec_a[0]   = decode_sample(req_left_sample, fmt_ff);
      dec_b[0]   = decode_sample(req_right_sample, fmt_ff);
      dec_a[1]   = decode_sample(req_below_sample, fmt_ff);
      dec_b[1]   = decode_sample(req_above_sample, fmt_ff);
      dec_a[2]   = decode_sample(req_out_sample, fmt_ff);
      dec_b[2]   = decode_sample(req_in_sample, fmt_ff);
      center_dec = decode_sample(req_center_sample, fmt_ff);
      for (int l = 0; l < LANES; l++) begin
         diff_in[l] = DIFF_W'(dec_a[l] - dec_b[l]);
      end
      // Signed division by 128 rounds toward zero: bias negatives first
      center_adj = center_dec + (center_dec[SAMPLE_W-1] ? S16_BIAS : '0);
      case (fmt_ff)
         vgn_pkg::FMT_S16: alpha_in = center_adj[S16_SHIFT +: BYTE_W];
         vgn_pkg::FMT_U16: alpha_in = center_dec[15:8];
         default:          alpha_in = center_dec[7:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_diff_ff  <= diff_in;
      s1_alpha_ff <= alpha_in;
   end

   // Stage 2: split each difference into sign and magnitude
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         abs_val[l] = s1_diff_ff[l][DIFF_W-1] ? DIFF_W'(-s1_diff_ff[l]) : s1_diff_ff[l];
         mag_in[l]  = abs_val[l][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_mag_ff <= mag_in;
      for (int l = 0; l < LANES; l++) begin
         s2_neg_ff[l] <= s1_diff_ff[l][DIFF_W-1];
      end
      s2_alpha_ff <= s1_alpha_ff;
   end

   // Stage 3: square each magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      for (int l = 0; l < LANES; l++) begin
         s3_sq_ff[l] <= SQ_W'(s2_mag_ff[l]) * SQ_W'(s2_mag_ff[l]);
      end
      s3_mag_ff   <= s2_mag_ff;
      s3_neg_ff   <= s2_neg_ff;
      s3_alpha_ff <= s2_alpha_ff;
   end

   // Stage 4: sum of squares
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_sum_ff   <= SUM_W'(s3_sq_ff[0]) + SUM_W'(s3_sq_ff[1]) + SUM_W'(s3_sq_ff[2]);
      s4_mag_ff   <= s3_mag_ff;
      s4_neg_ff   <= s3_neg_ff;
      s4_alpha_ff <= s3_alpha_ff;
   end

   // Stage 5: find the leading one and the even shift that aligns it
   always_comb begin
      msb = '0;
      for (int i = 0; i < SUM_W; i++) begin
         if (s4_sum_ff[i]) begin
            msb = MSB_W'(i);
         end
      end
      span = (MSB_W+1)'(vgn_pkg::ALIGN_MSB + 1) - {1'b0, msb};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_sum_ff    <= s4_sum_ff;
      s5_half_e_ff <= span[HALF_E_W:1];
      s5_zero_ff   <= (s4_sum_ff == '0);
      s5_mag_ff    <= s4_mag_ff;
      s5_neg_ff    <= s4_neg_ff;
      s5_alpha_ff  <= s4_alpha_ff;
   end

   // Stage 6: scale the sum by 2^e and each magnitude by 2^(e/2)
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         m_in[l] = ROOT_W'(s5_mag_ff[l]) << s5_half_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      s6_x_ff          <= X_W'(s5_sum_ff) << {s5_half_e_ff, 1'b0};
      s6_m_ff          <= m_in;
      s6_side_ff.zero  <= s5_zero_ff;
      s6_side_ff.neg   <= s5_neg_ff;
      s6_side_ff.alpha <= s5_alpha_ff;
   end

   // Root and divide stages
   vgn_norm_pipe #(
      .FRAC_BITS (NORM_FRAC_BITS)
   ) u_norm_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_valid_ff),
      .in_x      (s6_x_ff),
      .in_m      (s6_m_ff),
      .in_side   (s6_side_ff),
      .out_valid (pipe_valid),
      .out_q     (pipe_q),
      .out_side  (pipe_side)
   );

   // Bias, scale to a byte and clamp; a zero gradient gives the mid code
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         biased[l] = pipe_side.neg[l] ? V_ONE - {1'b0, pipe_q[l]} : V_ONE + {1'b0, pipe_q[l]};
         if (pipe_side.zero) begin
            normal_in[l] = NORMAL_MID;
         end else if (biased[l][NORM_FRAC_BITS+1]) begin
            normal_in[l] = BYTE_MAX;
         end else begin
            normal_in[l] = biased[l][NORM_FRAC_BITS-SCALE_SHIFT +: BYTE_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pipe_valid;
      end
      rsp_normal_ff <= normal_in;
      rsp_alpha_ff  <= pipe_side.alpha;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = rsp_normal_ff[0];
   assign rsp_normal_y   = rsp_normal_ff[1];
   assign rsp_normal_z   = rsp_normal_ff[2];
   assign rsp_alpha_byte = rsp_alpha_ff;

   // Every accepted beat comes out after the fixed latency
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted beat did not produce a result at the expected latency");

   // No result appears without a beat accepted the latency earlier
   a_latency_rev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result beat without a matching accepted beat");

   // A unit component never exceeds one
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (pipe_valid && !pipe_side.zero) |->
         (pipe_q[0] <= Q_ONE) && (pipe_q[1] <= Q_ONE) && (pipe_q[2] <= Q_ONE))
      else $error("normalized component above one");

endmodule

// ===== design/vgn_norm_pipe.sv =====
// Square root and three-lane divide pipeline.
// One root bit per stage, then one quotient bit per stage on all lanes.
module vgn_norm_pipe #(
   parameter int FRAC_BITS = vgn_pkg::NORM_FRAC_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   input  logic [vgn_pkg::X_W-1:0]                        in_x,
   input  logic [vgn_pkg::LANES-1:0][vgn_pkg::ROOT_W-1:0] in_m,
   input  vgn_pkg::side_type                              in_side,
   output logic                                           out_valid,
   output logic [vgn_pkg::LANES-1:0][FRAC_BITS:0]         out_q,
   output vgn_pkg::side_type                              out_side
);

   localparam int SQ_STAGES  = vgn_pkg::ROOT_W;
   localparam int DIV_STAGES = FRAC_BITS + 1;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int LANES      = vgn_pkg::LANES;
   localparam int ROOT_W     = vgn_pkg::ROOT_W;
   localparam int REM_W      = vgn_pkg::REM_W;
   localparam int X_W        = vgn_pkg::X_W;

   // Root stage registers
   logic                               sq_valid_ff [SQ_STAGES];
   logic [X_W-1:0]                     sq_x_ff     [SQ_STAGES];
   logic [ROOT_W-1:0]                  sq_root_ff  [SQ_STAGES];
   logic [REM_W-1:0]                   sq_rem_ff   [SQ_STAGES];
   logic [LANES-1:0][ROOT_W-1:0]       sq_m_ff     [SQ_STAGES];
   vgn_pkg::side_type                  sq_side_ff  [SQ_STAGES];

   // Divide stage registers
   logic                               dv_valid_ff [DIV_STAGES];
   logic [ROOT_W-1:0]                  dv_root_ff  [DIV_STAGES];
   logic [LANES-1:0][ROOT_W-1:0]       dv_rmd_ff   [DIV_STAGES];
   logic [LANES-1:0][Q_W-1:0]          dv_q_ff     [DIV_STAGES];
   vgn_pkg::side_type                  dv_side_ff  [DIV_STAGES];

   // Integer square root, one result bit per stage, two radicand bits consumed
   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
      logic                         valid_prev;
      logic [X_W-1:0]               x_prev;
      logic [ROOT_W-1:0]            root_prev;
      logic [REM_W-1:0]             rem_prev;
      logic [LANES-1:0][ROOT_W-1:0] m_prev;
      vgn_pkg::side_type            side_prev;
      logic [REM_W+1:0]             cur;
      logic [REM_W+1:0]             trial;
      logic [ROOT_W-1:0]            root_in;
      logic [REM_W-1:0]             rem_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign x_prev     = in_x;
         assign root_prev  = '0;
         assign rem_prev   = '0;
         assign m_prev     = in_m;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = sq_valid_ff[k-1];
         assign x_prev     = sq_x_ff[k-1];
         assign root_prev  = sq_root_ff[k-1];
         assign rem_prev   = sq_rem_ff[k-1];
         assign m_prev     = sq_m_ff[k-1];
         assign side_prev  = sq_side_ff[k-1];
      end

      // Bring down the next bit pair and try the next root bit
      always_comb begin
         cur   = {rem_prev, x_prev[X_W-1-2*k -: 2]};
         trial = {{(REM_W-ROOT_W){1'b0}}, root_prev, 2'b01};
         if (cur >= trial) begin
            rem_in  = REM_W'(cur - trial);
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur[REM_W-1:0];
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      // Advance one stage
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else begin
            sq_valid_ff[k] <= valid_prev;
         end
         sq_x_ff[k]    <= x_prev;
         sq_root_ff[k] <= root_in;
         sq_rem_ff[k]  <= rem_in;
         sq_m_ff[k]    <= m_prev;
         sq_side_ff[k] <= side_prev;
      end
   end

   // Restoring divide m * 2^F / root, one quotient bit per stage on each lane
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_dv
      logic                         valid_prev;
      logic [ROOT_W-1:0]            root_prev;
      logic [LANES-1:0][ROOT_W:0]   num_prev;
      logic [LANES-1:0][Q_W-1:0]    q_prev;
      vgn_pkg::side_type            side_prev;
      logic [LANES-1:0][ROOT_W-1:0] rmd_in;
      logic [LANES-1:0][Q_W-1:0]    q_in;

      if (j == 0) begin : g_first
         assign valid_prev = sq_valid_ff[SQ_STAGES-1];
         assign root_prev  = sq_root_ff[SQ_STAGES-1];
         assign side_prev  = sq_side_ff[SQ_STAGES-1];
         assign q_prev     = '0;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign num_prev[l] = {1'b0, sq_m_ff[SQ_STAGES-1][l]};
         end
      end else begin : g_next
         assign valid_prev = dv_valid_ff[j-1];
         assign root_prev  = dv_root_ff[j-1];
         assign side_prev  = dv_side_ff[j-1];
         assign q_prev     = dv_q_ff[j-1];
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign num_prev[l] = {dv_rmd_ff[j-1][l], 1'b0};
         end
      end

      // Compare and subtract on every lane
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (num_prev[l] >= {1'b0, root_prev}) begin
               rmd_in[l] = ROOT_W'(num_prev[l] - {1'b0, root_prev});
               q_in[l]   = {q_prev[l][Q_W-2:0], 1'b1};
            end else begin
               rmd_in[l] = num_prev[l][ROOT_W-1:0];
               q_in[l]   = {q_prev[l][Q_W-2:0], 1'b0};
            end
         end
      end

      // Advance one stage
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else begin
            dv_valid_ff[j] <= valid_prev;
         end
         dv_root_ff[j] <= root_prev;
         dv_rmd_ff[j]  <= rmd_in;
         dv_q_ff[j]    <= q_in;
         dv_side_ff[j] <= side_prev;
      end
   end

   assign out_valid = dv_valid_ff[DIV_STAGES-1];
   assign out_q     = dv_q_ff[DIV_STAGES-1];
   assign out_side  = dv_side_ff[DIV_STAGES-1];

endmodule

// ===== tb/sv/tb_volume_gradient_normal_encoder.sv =====
`timescale 1ns / 1ps

module tb_volume_gradient_normal_encoder;

   localparam int SAMPLE_W  = vgn_pkg::SAMPLE_W;
   localparam int BYTE_W    = vgn_pkg::BYTE_W;
   localparam int FMT_W     = vgn_pkg::FMT_W;
   localparam int FRAC      = vgn_pkg::NORM_FRAC_BITS_DEF;
   localparam int LATENCY   = FRAC + 39;
   localparam int STALL_MAX = 1000;
   localparam int SHOW_MAX  = 10;
   localparam int PHASE_LEN = 150;
   localparam int PHASES    = 9;

   // spare format code, decoded as unsigned byte
   localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;

   // sample slots in a voxel: left, right, below, above, out, in, center
   localparam int LEFT   = 0;
   localparam int RIGHT  = 1;
   localparam int BELOW  = 2;
   localparam int ABOVE  = 3;
   localparam int OUTER  = 4;
   localparam int INNER  = 5;
   localparam int CENTER = 6;

   typedef logic [6:0][SAMPLE_W-1:0] voxel_type;

   typedef struct packed {
      logic [BYTE_W-1:0] nx;
      logic [BYTE_W-1:0] ny;
      logic [BYTE_W-1:0] nz;
      logic [BYTE_W-1:0] alpha;
   } normal_beat_type;

   typedef struct packed {
      logic [FMT_W-1:0] fmt;
      voxel_type        smp;
      logic             typed;
      normal_beat_type  want;
   } voxel_row_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic signed [SAMPLE_W-1:0] req_left_sample;
   logic signed [SAMPLE_W-1:0] req_right_sample;
   logic signed [SAMPLE_W-1:0] req_below_sample;
   logic signed [SAMPLE_W-1:0] req_above_sample;
   logic signed [SAMPLE_W-1:0] req_out_sample;
   logic signed [SAMPLE_W-1:0] req_in_sample;
   logic signed [SAMPLE_W-1:0] req_center_sample;
   logic                       rsp_valid;
   logic [BYTE_W-1:0]          rsp_normal_x;
   logic [BYTE_W-1:0]          rsp_normal_y;
   logic [BYTE_W-1:0]          rsp_normal_z;
   logic [BYTE_W-1:0]          rsp_alpha_byte;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [FMT_W-1:0]           csr_sample_format;

   logic [FMT_W-1:0] cur_format;
   normal_beat_type  expected_normals[$];
   voxel_row_type    directed_rows[$];
   int               mismatch_count = 0;
   int               voxel_count    = 0;
   int               format_writes  = 0;
   int               drain_pauses   = 0;
   int               stall_cycles   = 0;

   volume_gradient_normal_encoder dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_left_sample   (req_left_sample),
      .req_right_sample  (req_right_sample),
      .req_below_sample  (req_below_sample),
      .req_above_sample  (req_above_sample),
      .req_out_sample    (req_out_sample),
      .req_in_sample     (req_in_sample),
      .req_center_sample (req_center_sample),
      .rsp_valid         (rsp_valid),
      .rsp_normal_x      (rsp_normal_x),
      .rsp_normal_y      (rsp_normal_y),
      .rsp_normal_z      (rsp_normal_z),
      .rsp_alpha_byte    (rsp_alpha_byte),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_sample_format (csr_sample_format)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sample value as the block reads it under a given format
   function automatic longint decode_sample(logic [FMT_W-1:0] fmt, logic [SAMPLE_W-1:0] raw);
      case (fmt)
         vgn_pkg::FMT_S16: return longint'($signed(raw[15:0]));
         vgn_pkg::FMT_U16: return longint'(raw[15:0]);
         default:          return longint'(raw[7:0]);
      endcase
   endfunction

   // Bitwise integer square root, floor
   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned bit_v;
      root  = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
         if (x >= root + bit_v) begin
            x    = x - (root + bit_v);
            root = (root >> 1) + bit_v;
         end else begin
            root = root >> 1;
         end
         bit_v >>= 2;
      end
      return root;
   endfunction

   // Unit component in fixed point, biased to a byte and clamped
   function automatic logic [BYTE_W-1:0] bias_component(longint g, int half_e,
                                                        longint unsigned root);
      longint unsigned mag;
      longint unsigned q;
      longint          v;
      mag = (g < 0) ? -g : g;
      q   = (mag << (FRAC + half_e)) / root;
      v   = (g < 0) ? -longint'(q) : longint'(q);
      v   = v + (longint'(1) << FRAC);
      if (v < 0) v = 0;
      v = (v * 128) >>> FRAC;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // Expected normal and alpha for one voxel
   function automatic normal_beat_type predict_normal(logic [FMT_W-1:0] fmt, voxel_type v);
      longint          gx;
      longint          gy;
      longint          gz;
      longint          c;
      longint          quo;
      longint unsigned s;
      longint unsigned root;
      int              e;
      normal_beat_type r;
      gx = decode_sample(fmt, v[LEFT])  - decode_sample(fmt, v[RIGHT]);
      gy = decode_sample(fmt, v[BELOW]) - decode_sample(fmt, v[ABOVE]);
      gz = decode_sample(fmt, v[OUTER]) - decode_sample(fmt, v[INNER]);
      c  = decode_sample(fmt, v[CENTER]);
      s  = gx * gx + gy * gy + gz * gz;
      if (s == 0) begin
         r.nx = 8'd128;
         r.ny = 8'd128;
         r.nz = 8'd128;
      end else begin
         e = 0;
         while ((s << e) < (64'd1 << vgn_pkg::ALIGN_MSB)) e += 2;
         root = floor_sqrt(s << e);
         r.nx = bias_component(gx, e / 2, root);
         r.ny = bias_component(gy, e / 2, root);
         r.nz = bias_component(gz, e / 2, root);
      end
      case (fmt)
         vgn_pkg::FMT_S16: begin
            quo     = c / 128;
            r.alpha = quo[7:0];
         end
         vgn_pkg::FMT_U16: begin
            quo     = c >>> 8;
            r.alpha = quo[7:0];
         end
         default: r.alpha = c[7:0];
      endcase
      return r;
   endfunction

   // Count a mismatch, show only the first few
   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= SHOW_MAX) $display("mismatch: %s", what);
   endfunction

   function automatic void add_row(logic [FMT_W-1:0] fmt, int lf, int rt, int bl, int ab,
                                   int ou, int ins, int ce, logic typed,
                                   int nx, int ny, int nz, int al);
      voxel_row_type row;
      row.fmt         = fmt;
      row.smp[LEFT]   = lf[SAMPLE_W-1:0];
      row.smp[RIGHT]  = rt[SAMPLE_W-1:0];
      row.smp[BELOW]  = bl[SAMPLE_W-1:0];
      row.smp[ABOVE]  = ab[SAMPLE_W-1:0];
      row.smp[OUTER]  = ou[SAMPLE_W-1:0];
      row.smp[INNER]  = ins[SAMPLE_W-1:0];
      row.smp[CENTER] = ce[SAMPLE_W-1:0];
      row.typed       = typed;
      row.want.nx     = nx[7:0];
      row.want.ny     = ny[7:0];
      row.want.nz     = nz[7:0];
      row.want.alpha  = al[7:0];
      directed_rows.push_back(row);
   endfunction

   // Directed table: extremes per axis and format, bits above the sample width,
   // signed alpha truncation, the spare format code
   function automatic void build_directed_rows();
      //       fmt               left    right   below  above  out  in   center typed x y z a
      add_row(vgn_pkg::FMT_U8,  0,      0,      0,     0,     0,   0,     0,      1,
              128, 128, 128, 0);
      add_row(vgn_pkg::FMT_U8,  255,    0,      0,     0,     0,   0,     0,      1,
              255, 128, 128, 0);
      add_row(vgn_pkg::FMT_U8,  0,      255,    0,     0,     0,   0,     1,      1,
              0,   128, 128, 1);
      add_row(vgn_pkg::FMT_U8,  0,      0,      255,   0,     0,   0,     255,    1,
              128, 255, 128, 255);
      add_row(vgn_pkg::FMT_U8,  0,      0,      0,     255,   0,   0,     0,      1,
              128, 0,   128, 0);
      add_row(vgn_pkg::FMT_U8,  0,      0,      0,     0,     255, 0,     0,      1,
              128, 128, 255, 0);
      add_row(vgn_pkg::FMT_U8,  0,      0,      0,     0,     0,   255,   0,      1,
              128, 128, 0,   0);
      add_row(vgn_pkg::FMT_U8,  -256,   0,      0,     0,     0,   0,     -32384, 1,
              128, 128, 128, 128);
      add_row(vgn_pkg::FMT_U8,  255,    0,      255,   0,     255, 0,     77,     0,
              0,   0,   0,   0);
      add_row(vgn_pkg::FMT_U8,  3,      0,      4,     0,     0,   0,     9,      0,
              0,   0,   0,   0);
      add_row(vgn_pkg::FMT_S16, 32767,  -32768, 0,     0,     0,   0,     -32768, 1,
              255, 128, 128, 0);
      add_row(vgn_pkg::FMT_S16, -32768, 32767,  0,     0,     0,   0,     32767,  1,
              0,   128, 128, 255);
      add_row(vgn_pkg::FMT_S16, 65535,  0,      0,     0,     0,   0,     65535,  1,
              0,   128, 128, 0);
      add_row(vgn_pkg::FMT_S16, 5,      5,      5,     5,     5,   5,     -129,   1,
              128, 128, 128, 255);
      add_row(vgn_pkg::FMT_S16, 5,      5,      5,     5,     5,   5,     -127,   1,
              128, 128, 128, 0);
      add_row(vgn_pkg::FMT_S16, -100,   250,    32767, -5,    -32768, 17, -300,   0,
              0,   0,   0,   0);
      add_row(vgn_pkg::FMT_U16, 65535,  65535,  65535, 65535, 65535, 65535, 65535, 1,
              128, 128, 128, 255);
      add_row(vgn_pkg::FMT_U16, 65535,  0,      0,     0,     0,   0,     256,    1,
              255, 128, 128, 1);
      add_row(vgn_pkg::FMT_U16, 0,      0,      0,     65535, 0,   0,     255,    1,
              128, 0,   128, 0);
      add_row(vgn_pkg::FMT_U16, 1,      0,      0,     1,     1,   0,     0,      0,
              0,   0,   0,   0);
      add_row(vgn_pkg::FMT_U16, -32768, 0,      1000,  3,     0,   40000, -1,     0,
              0,   0,   0,   0);
      add_row(FMT_SPARE,        255,    0,      0,     0,     0,   0,     427,    1,
              255, 128, 128, 171);
      add_row(FMT_SPARE,        300,    -7,     12,    200,   64,  63,    -2,     0,
              0,   0,   0,   0);
   endfunction

   // Minimum, maximum or random value in a format's native range
   function automatic int native_value(logic [FMT_W-1:0] fmt, int pick);
      int lo;
      int hi;
      case (fmt)
         vgn_pkg::FMT_S16: begin
            lo = -32768;
            hi = 32767;
         end
         vgn_pkg::FMT_U16: begin
            lo = 0;
            hi = 65535;
         end
         default: begin
            lo = 0;
            hi = 255;
         end
      endcase
      if (pick == 0) return lo;
      if (pick == 1) return hi;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Random voxel: mostly smooth surfaces around a center, plus single-axis,
   // flat, saturated and raw-noise voxels
   function automatic voxel_type random_voxel(logic [FMT_W-1:0] fmt);
      voxel_type v;
      int        shape;
      int        base;
      int        axis;
      int        val;
      int        k;
      shape = $urandom_range(0, 9);
      base  = native_value(fmt, 2);
      axis  = $urandom_range(0, 2);
      for (k = 0; k < 7; k++) begin
         case (shape)
            0, 1: val = int'($urandom_range(0, 98303)) - 32768;
            2, 3, 4, 5, 6: begin
               val = (k == CENTER) ? base : base + int'($urandom_range(0, 16)) - 8;
               if (val < -32768) val = -32768;
               if (val > 65535) val = 65535;
            end
            7: val = (k / 2 == axis && k != CENTER) ? native_value(fmt, $urandom_range(0, 3))
                                                    : base;
            8: val = base;
            default: val = native_value(fmt, $urandom_range(0, 3));
         endcase
         v[k] = val[SAMPLE_W-1:0];
      end
      return v;
   endfunction

   // Drive one voxel beat and hold it until taken
   task automatic send_voxel(voxel_type v, logic typed, normal_beat_type want);
      @(negedge clock);
      start             <= 1'b1;
      req_left_sample   <= v[LEFT];
      req_right_sample  <= v[RIGHT];
      req_below_sample  <= v[BELOW];
      req_above_sample  <= v[ABOVE];
      req_out_sample    <= v[OUTER];
      req_in_sample     <= v[INNER];
      req_center_sample <= v[CENTER];
      do @(posedge clock); while (busy);
      expected_normals.push_back(typed ? want : predict_normal(cur_format, v));
      voxel_count++;
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Hold off until every expected beat has come back
   task automatic drain_expected();
      @(negedge clock);
      start <= 1'b0;
      while (expected_normals.size() != 0) @(negedge clock);
   endtask

   task automatic write_format(logic [FMT_W-1:0] fmt);
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_sample_format <= fmt;
      do @(posedge clock); while (!csr_ready);
      cur_format = fmt;
      format_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      normal_beat_type want;
      if (!reset && rsp_valid) begin
         if (expected_normals.size() == 0) begin
            note_mismatch($sformatf("unexpected beat x=%0d y=%0d z=%0d a=%0d",
                                    rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_alpha_byte));
         end else begin
            want = expected_normals.pop_front();
            if (rsp_normal_x !== want.nx || rsp_normal_y !== want.ny ||
                rsp_normal_z !== want.nz || rsp_alpha_byte !== want.alpha) begin
               note_mismatch($sformatf(
                  "expected x=%0d y=%0d z=%0d a=%0d, got x=%0d y=%0d z=%0d a=%0d",
                  want.nx, want.ny, want.nz, want.alpha,
                  rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_alpha_byte));
            end
         end
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_MAX) begin
            $display("tb_volume_gradient_normal_encoder: done, errors");
            $finish;
         end
      end
   end

   initial begin
      voxel_row_type    row;
      normal_beat_type  no_beat;
      logic [FMT_W-1:0] fmt;
      int               sent;
      int               burst;
      no_beat           = '0;
      reset             = 1'b1;
      start             = 1'b0;
      req_left_sample   = '0;
      req_right_sample  = '0;
      req_below_sample  = '0;
      req_above_sample  = '0;
      req_out_sample    = '0;
      req_in_sample     = '0;
      req_center_sample = '0;
      csr_valid         = 1'b0;
      csr_sample_format = vgn_pkg::FMT_U8;
      cur_format        = vgn_pkg::FMT_U8;
      build_directed_rows();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table, switching format only when idle
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (i == 0 || row.fmt != cur_format) begin
            drain_expected();
            write_format(row.fmt);
         end
         send_voxel(row.smp, row.typed, row.want);
         if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 4));
      end

      // Random phases: fixed formats first, then random ones
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: fmt = vgn_pkg::FMT_U16;
            1: fmt = vgn_pkg::FMT_U8;
            2: fmt = vgn_pkg::FMT_S16;
            3: fmt = FMT_SPARE;
            default: fmt = FMT_W'($urandom_range(0, 3));
         endcase
         drain_expected();
         write_format(fmt);
         sent = 0;
         while (sent < PHASE_LEN) begin
            burst = $urandom_range(1, 32);
            repeat (burst) begin
               if (sent < PHASE_LEN) begin
                  send_voxel(random_voxel(cur_format), 1'b0, no_beat);
                  sent++;
               end
            end
            if ($urandom_range(0, 29) == 0) begin
               drain_expected();
               drain_pauses++;
            end else if ($urandom_range(0, 3) != 0) begin
               idle_cycles($urandom_range(1, 12));
            end
         end
      end

      // Wait out the pipeline, then give any stray beat time to show
      drain_expected();
      repeat (LATENCY + 5) @(posedge clock);

      $display("run covered %0d voxels over %0d format writes, all four format codes,",
               voxel_count, format_writes);
      $display("bursty input with %0d mid-phase drains; %0d mismatches",
               drain_pauses, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_volume_gradient_normal_encoder: done, clean");
      end else begin
         $display("tb_volume_gradient_normal_encoder: done, errors");
      end
      $finish;
   end

endmodule
